// ===== hw/rtl/cabn_pkg.sv =====
// package for the class-aware box suppression unit
// shared types, constants and encodings; no dependencies
package cabn_pkg;
    localparam int MaxKeptDefault = 64;
    localparam int CoordW = 16;
    localparam int ClassW = 8;
    localparam int ThrW = 9;
    localparam int LimW = 7;
    localparam int EntryW = ClassW + 4 * CoordW;

    localparam logic [1:0] CfgIou = 2'd0;
    localparam logic [1:0] CfgContain = 2'd1;
    localparam logic [1:0] CfgLimit = 2'd2;

    localparam logic [1:0] VerdictKept = 2'd0;
    localparam logic [1:0] VerdictSupp = 2'd1;
    localparam logic [1:0] VerdictDrop = 2'd2;

    typedef enum logic [2:0] {
        t_st_idle, t_st_check, t_st_read, t_st_wait, t_st_fin, t_st_out
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic start_cmp;
        logic append;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic more;
        logic hit;
        logic pipe_busy;
    } t_status;
endpackage

// ===== hw/rtl/cabn_ram.sv =====
// generic single-port-write, registered-read ram
// no dependencies
module cabn_ram #(
    parameter int Width = 8,
    parameter int Depth = 64,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/cabn_ctrl.sv =====
// controller state machine for box suppression
// depends on cabn_pkg
module cabn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_frame_start,
    input  logic              i_out_fire,
    input  cabn_pkg::t_status i_status,
    output cabn_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import cabn_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_st_idle: if (i_in_fire) n_state = t_st_check;
            t_st_check: begin
                if (i_status.full) n_state = t_st_out;
                else if (i_status.more) n_state = t_st_read;
                else n_state = t_st_fin;
            end
            t_st_read: if (!i_status.more) n_state = t_st_wait;
            t_st_wait: if (!i_status.pipe_busy) n_state = t_st_fin;
            t_st_fin: n_state = t_st_out;
            t_st_out: if (i_out_fire) n_state = t_st_idle;
            default: n_state = t_st_idle;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            t_st_idle: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
                o_cmd.clear = i_in_fire & i_frame_start;
            end
            t_st_check: o_cmd.start_cmp = 1'b1;
            t_st_fin: o_cmd.append = !i_status.hit;
            t_st_out: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/cabn_dp.sv =====
// datapath: kept table, overlap pipeline, counters and result register
// depends on cabn_pkg and cabn_ram
module cabn_dp #(
    parameter int MaxKept = cabn_pkg::MaxKeptDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cabn_pkg::t_cmd                i_cmd,
    input  logic [cabn_pkg::EntryW-1:0]   i_cand,
    input  logic [cabn_pkg::ThrW-1:0]     i_iou_thr,
    input  logic [cabn_pkg::ThrW-1:0]     i_con_thr,
    input  logic [cabn_pkg::LimW-1:0]     i_limit,
    output cabn_pkg::t_status             o_status,
    output logic                          o_kept,
    output logic [1:0]                    o_verdict,
    output logic [cabn_pkg::LimW-1:0]     o_total
);
    import cabn_pkg::*;

    localparam int AW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
    localparam int CW = $clog2(MaxKept + 1);
    localparam int AreaW = 2 * CoordW;
    localparam int LimCmpW = ((LimW > CW) ? LimW : CW) + 1;

    logic [EntryW-1:0] r_cand;
    logic [CW-1:0]     r_count, r_idx;
    logic              r_hit, r_full;
    logic [1:0]        r_verdict;
    logic              r_kept;

    logic [CW-1:0] eff_lim;
    logic [CW-1:0] cnt_now;
    always_comb begin
        if (i_limit == '0 || LimCmpW'(i_limit) > LimCmpW'(MaxKept)) eff_lim = CW'(MaxKept);
        else eff_lim = CW'(i_limit);
    end
    assign cnt_now = r_count;

    // table read
    logic [EntryW-1:0] rd;
    logic              rd_en;
    assign rd_en = (i_cmd.start_cmp || r_idx != '0) && r_idx < r_count && !r_hit;
    cabn_ram #(.Width(EntryW), .Depth(MaxKept)) u_tab (
        .i_clk(i_clk), .i_we(i_cmd.append), .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_cand), .i_raddr(r_idx[AW-1:0]), .o_rdata(rd)
    );

    // pipeline: s1 data valid, s2 geometry, s3 areas, s4 union and smaller area, s5 threshold products; compare on s5
    logic r_v1, r_v2, r_v3, r_v4;
    logic [CoordW-1:0] cl, ct, cr, cb, kl, kt, kr, kb;
    assign {cb, cr, ct, cl} = r_cand[4*CoordW-1:0];
    assign {kb, kr, kt, kl} = rd[4*CoordW-1:0];

    function automatic logic [CoordW-1:0] span(input logic [CoordW-1:0] lo, hi);
        span = (hi > lo) ? hi - lo : '0;
    endfunction

    logic r_cls2;
    logic [CoordW-1:0] r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic r_cls3;
    logic [AreaW-1:0] r_in, r_aa, r_ab;
    logic [AreaW+ThrW:0] r_lhs;
    logic [AreaW:0] r_un;
    logic [AreaW-1:0] r_sm;
    logic r_cls4;
    logic [AreaW+8:0] r_lhs4;
    logic [AreaW+ThrW:0] r_pu, r_ps;
    logic r_cls5, r_v5;

    always_ff @(posedge i_clk) begin
        r_cls2 <= rd[EntryW-1 -: ClassW] == r_cand[EntryW-1 -: ClassW];
        r_iw <= span((cl > kl) ? cl : kl, (cr < kr) ? cr : kr);
        r_ih <= span((ct > kt) ? ct : kt, (cb < kb) ? cb : kb);
        r_aw <= span(cl, cr); r_ah <= span(ct, cb);
        r_bw <= span(kl, kr); r_bh <= span(kt, kb);
        r_cls3 <= r_cls2;
        r_in <= r_iw * r_ih;
        r_aa <= r_aw * r_ah;
        r_ab <= r_bw * r_bh;
        r_cls4 <= r_cls3;
        r_lhs4 <= (AreaW + 9)'({r_in, 8'd0});
        r_un <= {1'b0, r_aa} + {1'b0, r_ab} - {1'b0, r_in};
        r_sm <= (r_aa < r_ab) ? r_aa : r_ab;
        r_cls5 <= r_cls4;
        r_lhs <= (AreaW + ThrW + 1)'(r_lhs4);
        r_pu <= (AreaW + ThrW + 1)'(r_un * i_iou_thr);
        r_ps <= (AreaW + ThrW + 1)'(r_sm * i_con_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else begin
            r_v1 <= rd_en; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
        end
    end

    logic hit_now;
    assign hit_now = r_v5 && r_cls5 &&
        (r_lhs > r_pu || (i_con_thr != '0 && r_lhs > r_ps));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_idx <= '0; r_hit <= 1'b0; r_full <= 1'b0;
            r_kept <= 1'b0; r_verdict <= VerdictKept;
        end else begin
            if (i_cmd.load) begin
                r_cand <= i_cand;
                r_idx <= '0;
                r_hit <= 1'b0;
                if (i_cmd.clear) r_count <= '0;
            end else begin
                // after an append the scan index moves past the new entry so no read restarts
                if (rd_en) r_idx <= r_idx + 1'b1;
                else if (i_cmd.append) r_idx <= r_count + 1'b1;
                if (hit_now) r_hit <= 1'b1;
            end
            if (i_cmd.start_cmp) begin
                r_full <= cnt_now >= eff_lim;
                if (cnt_now >= eff_lim) begin
                    r_kept <= 1'b0; r_verdict <= VerdictDrop;
                end
            end
            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
                r_kept <= 1'b1; r_verdict <= VerdictKept;
            end else if (r_hit && !r_full && !i_cmd.start_cmp) begin
                r_kept <= 1'b0; r_verdict <= VerdictSupp;
            end
        end
    end

    assign o_status.full = cnt_now >= eff_lim;
    assign o_status.more = rd_en;
    assign o_status.hit = r_hit | hit_now;
    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_kept = r_kept;
    assign o_verdict = r_verdict;
    assign o_total = LimW'(r_count);
endmodule

// ===== hw/rtl/class_aware_box_nms_unit.sv =====
// class-aware greedy box suppression, top level
// one word in flight: a new word is accepted only after the last result is taken
// (kept boxes are compared one per cycle through a five-stage overlap pipeline)
// reset: synchronous active low; clears kept count, registers to defaults
// depends on cabn_pkg, cabn_ctrl, cabn_dp, cabn_ram
module class_aware_box_nms_unit #(
    parameter int MAX_KEPT = cabn_pkg::MaxKeptDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // class_index[7:0], box_left, box_top, box_right, box_bottom
    input  logic [71:0] s_axis_tdata,
    // frame_start
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kept[0], verdict[2:1], kept_total[9:3], zero pad
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import cabn_pkg::*;

    // configuration registers
    logic [ThrW-1:0] r_iou, r_con;
    logic [LimW-1:0] r_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou <= 9'd128; r_con <= '0; r_lim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgIou: r_iou <= i_cfg_data;
                CfgContain: r_con <= i_cfg_data;
                CfgLimit: r_lim <= i_cfg_data[LimW-1:0];
                default: ;
            endcase
        end
    end

    t_cmd    cmd;
    t_status st;
    logic    in_fire, out_fire;
    logic    kept;
    logic [1:0] verdict;
    logic [LimW-1:0] total;

    assign in_fire = s_axis_tvalid & s_axis_tready;
    assign out_fire = m_axis_tvalid & m_axis_tready;

    cabn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_frame_start(s_axis_tuser), .i_out_fire(out_fire), .i_status(st),
        .o_cmd(cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    // table entry: class in top bits, then bottom, right, top, left
    cabn_dp #(.MaxKept(MAX_KEPT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cand({s_axis_tdata[7:0], s_axis_tdata[71:8]}),
        .i_iou_thr(r_iou), .i_con_thr(r_con), .i_limit(r_lim),
        .o_status(st), .o_kept(kept), .o_verdict(verdict), .o_total(total)
    );

    assign m_axis_tdata = {6'd0, total, verdict, kept};
endmodule

// ===== tb/tb.sv =====
// testbench for class_aware_box_nms_unit: drives candidate boxes, predicts verdicts
// depends on cabn_pkg and the unit's rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cabn_pkg::*;

    localparam int MaxKept = 64;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic        frame_start;
        logic [7:0]  cls;
        logic [15:0] left, top, right, bottom;
    } cand_t;

    // lowest bit first on the bus: kept, verdict, total
    typedef struct packed {
        logic [6:0] total;
        logic [1:0] verdict;
        logic       kept;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // class_index, box_left, box_top, box_right, box_bottom
    logic [71:0] s_axis_tdata = '0;
    // frame_start
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // kept, verdict, kept_total, zero pad
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;

    class_aware_box_nms_unit u_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [8:0]  iou_thr, cont_thr;
    logic [6:0]  det_limit;
    cand_t       table_box [MaxKept];
    int unsigned table_cnt;

    cand_t    pending_cands[$];
    verdict_t expected_verdicts[$];
    int       mismatches = 0;
    bit       hold_off = 0;
    int       idle_cycles = 0;

    function automatic longint unsigned span16(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    function automatic bit overlap_hit(cand_t a, cand_t b);
        longint unsigned iw, ih, inter, area_a, area_b, uni, smaller;
        iw = span16((a.left > b.left) ? a.left : b.left,
                    (a.right < b.right) ? a.right : b.right);
        ih = span16((a.top > b.top) ? a.top : b.top,
                    (a.bottom < b.bottom) ? a.bottom : b.bottom);
        inter = iw * ih;
        area_a = span16(a.left, a.right) * span16(a.top, a.bottom);
        area_b = span16(b.left, b.right) * span16(b.top, b.bottom);
        uni = area_a + area_b - inter;
        smaller = (area_a < area_b) ? area_a : area_b;
        if (inter * 256 > longint'(iou_thr) * uni) return 1;
        if (cont_thr != 0 && inter * 256 > longint'(cont_thr) * smaller) return 1;
        return 0;
    endfunction

    function automatic verdict_t judge_candidate(cand_t c);
        verdict_t    v;
        int unsigned lim;
        v = '0;
        if (c.frame_start) table_cnt = 0;
        lim = (det_limit == 0 || det_limit > MaxKept) ? MaxKept : det_limit;
        if (table_cnt >= lim) begin
            v.verdict = VerdictDrop;
        end else begin
            v.verdict = VerdictKept;
            for (int i = 0; i < table_cnt; i++) begin
                if (table_box[i].cls == c.cls && overlap_hit(c, table_box[i])) begin
                    v.verdict = VerdictSupp;
                    break;
                end
            end
            if (v.verdict == VerdictKept) begin
                table_box[table_cnt] = c;
                table_cnt++;
                v.kept = 1'b1;
            end
        end
        v.total = table_cnt[6:0];
        return v;
    endfunction

    function automatic void add_cand(cand_t c);
        pending_cands.insert(pending_cands.size(), c);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // predictor: judge each word as it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     judge_candidate(pending_cands.pop_front()));
        end
    end

    // driver: offers pending words, gaps at random
    int tx_gap = 0;
    bit word_taken = 0;
    always @(posedge i_clk) word_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || word_taken)) begin
            if (tx_gap > 0 || pending_cands.size() == 0 ||
                (word_taken && pending_cands.size() == 0)) begin
                s_axis_tvalid <= 1'b0;
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
            end else begin
                // the head of the queue is the next word once the last one is taken
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_cands[0].frame_start;
                s_axis_tdata <= {pending_cands[0].bottom, pending_cands[0].right,
                                 pending_cands[0].top, pending_cands[0].left,
                                 pending_cands[0].cls};
                tx_gap <= gap_len();
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tready) rx_gap <= gap_len();
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        verdict_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[9:0];
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                if (got.kept !== want.kept || got.verdict !== want.verdict ||
                    got.total !== want.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: exp kept %0d verdict %0d total %0d, got %0d %0d %0d",
                                 want.kept, want.verdict, want.total,
                                 got.kept, got.verdict, got.total);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            !i_rst_n || hold_off || (pending_cands.size() == 0 &&
            expected_verdicts.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("class_aware_box_nms_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgIou:     iou_thr = val;
            CfgContain: cont_thr = val;
            default:    det_limit = val[6:0];
        endcase
    endtask

    task automatic drain();
        wait (pending_cands.size() == 0 && !s_axis_tvalid && expected_verdicts.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic cand_t make_box(bit fs, logic [7:0] cls, int wide);
        cand_t c;
        int    w, h;
        c.frame_start = fs;
        c.cls = cls;
        if (wide) begin
            c.left = 16'($urandom); c.top = 16'($urandom);
            c.right = 16'($urandom); c.bottom = 16'($urandom);
        end else begin
            // boxes clustered so that overlaps are frequent
            c.left = 16'($urandom_range(0, 400));
            c.top = 16'($urandom_range(0, 400));
            w = $urandom_range(0, 300);
            h = $urandom_range(0, 300);
            c.right = 16'(c.left + w);
            c.bottom = 16'(c.top + h);
            if ($urandom_range(0, 19) == 0) c.right = 16'(c.left - $urandom_range(1, 50));
        end
        return c;
    endfunction

    task automatic random_frames(int n, int classes);
        for (int i = 0; i < n; i++)
            add_cand(make_box(i == 0 || $urandom_range(0, 29) == 0,
                              8'($urandom_range(0, classes - 1)),
                              $urandom_range(0, 15) == 0));
    endtask

    initial begin
        iou_thr = 9'd128; cont_thr = '0; det_limit = '0; table_cnt = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, inverted edges, identical boxes, other class, area zero
        add_cand('{1'b1, 8'd0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF});
        add_cand('{1'b0, 8'd0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF});
        add_cand('{1'b0, 8'hFF, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF});
        add_cand('{1'b0, 8'hAA, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0});
        add_cand('{1'b0, 8'hAA, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0});
        add_cand('{1'b0, 8'h55, 16'd10, 16'd10, 16'd10, 16'd20});
        add_cand('{1'b0, 8'h55, 16'd10, 16'd10, 16'd30, 16'd30});
        add_cand('{1'b0, 8'h55, 16'd12, 16'd12, 16'd28, 16'd28});
        add_cand('{1'b1, 8'd3, 16'd0, 16'd0, 16'd100, 16'd100});
        add_cand('{1'b0, 8'd3, 16'd50, 16'd0, 16'd150, 16'd100});
        drain();

        // containment on, limit 2 so drops show up
        write_reg(CfgContain, 9'd200);
        write_reg(CfgLimit, 9'd2);
        add_cand('{1'b1, 8'd1, 16'd0, 16'd0, 16'd100, 16'd100});
        add_cand('{1'b0, 8'd1, 16'd10, 16'd10, 16'd20, 16'd20});
        add_cand('{1'b0, 8'd2, 16'd10, 16'd10, 16'd20, 16'd20});
        add_cand('{1'b0, 8'd2, 16'd500, 16'd500, 16'd600, 16'd600});
        add_cand('{1'b1, 8'd2, 16'd500, 16'd500, 16'd600, 16'd600});
        drain();

        // thresholds at both ends, limit past capacity
        write_reg(CfgIou, 9'd0);
        write_reg(CfgContain, 9'd256);
        write_reg(CfgLimit, 9'd127);
        random_frames(150, 3);
        drain();

        write_reg(CfgIou, 9'd511);
        write_reg(CfgContain, 9'd0);
        write_reg(CfgLimit, 9'd64);
        random_frames(150, 2);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_reg(CfgIou, 9'd256);
        write_reg(CfgLimit, 9'd0);
        hold_off = 1;
        random_frames(200, 8);
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
        drain();

        write_reg(CfgIou, 9'd77);
        write_reg(CfgContain, 9'd1);
        write_reg(CfgLimit, 9'd10);
        random_frames(180, 4);
        drain();

        write_reg(CfgIou, 9'd128);
        write_reg(CfgContain, 9'd100);
        write_reg(CfgLimit, 9'd1);
        random_frames(150, 256);
        drain();

        if (mismatches == 0)
            $display("class_aware_box_nms_unit: match");
        else
            $display("class_aware_box_nms_unit: mismatch");
        $finish;
    end
endmodule
